// ===== src/fdss_pkg.sv =====
`timescale 1ns / 1ps

package fdss_pkg;

    localparam int unsigned NumDigits = 4;

    localparam logic [7:0] START_BYTE = 8'h58;  // 'X'
    localparam logic [7:0] END_BYTE   = 8'h59;  // 'Y'

    // frame hunter phases: 1..6 take payload, 7 waits for the end byte
    localparam logic [2:0] PH_HUNT     = 3'd0;
    localparam logic [2:0] PH_LAST_KEEP = 3'd4;
    localparam logic [2:0] PH_END      = 3'd7;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef logic [4:0] code_t;
    typedef code_t [NumDigits-1:0] code_arr_t;

    typedef struct packed {
        logic       en;
        logic [7:0] data;
    } byte_req_t;

    localparam logic [6:0] SHAPES [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h67
    };

    function automatic code_t code_from_byte(input logic [7:0] b);
        code_from_byte = {b[6], b[3:0]};
    endfunction

    function automatic logic [7:0] segments_for(input code_t code);
        logic [7:0] seg;
        seg = 8'h00;
        if (code[3:0] <= 4'd9)
        begin
            seg = {code[4], SHAPES[code[3:0]]};
        end
        segments_for = seg;
    endfunction

endpackage

// ===== src/fdss_framer.sv =====
`timescale 1ns / 1ps

module fdss_framer
    import fdss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  byte_req_t byte_req,
    output code_arr_t digit_codes
);

    logic [2:0] phase_reg;
    logic [2:0] phase_next;
    code_arr_t  pending_reg;
    code_arr_t  digit_codes_reg;
    logic [1:0] pend_idx;
    logic       load_codes;

    assign pend_idx   = 2'(phase_reg - 3'd1);
    assign load_codes = byte_req.en && (phase_reg == PH_END) && (byte_req.data == END_BYTE);

    always_comb
    begin
        phase_next = phase_reg;
        if (byte_req.en)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (byte_req.data == START_BYTE)
                    begin
                        phase_next = 3'd1;
                    end
                end
                PH_END:  phase_next = PH_HUNT;
                default: phase_next = phase_reg + 3'd1;
            endcase
        end
    end

    // staging codes: no reset, every entry rewritten before the end byte
    always_ff @(posedge clk)
    begin
        if (byte_req.en && (phase_reg != PH_HUNT) && (phase_reg <= PH_LAST_KEEP))
        begin
            pending_reg[pend_idx] <= code_from_byte(byte_req.data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT;
            digit_codes_reg <= {5'd4, 5'd3, 5'd2, 5'd1};
        end
        else
        begin
            phase_reg <= phase_next;
            if (load_codes)
            begin
                digit_codes_reg <= pending_reg;
            end
        end
    end

    assign digit_codes = digit_codes_reg;

    a_end_returns_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        byte_req.en && (phase_reg == PH_END) |=> phase_reg == PH_HUNT)
        else $error("frame end did not return to hunting");

    a_codes_change_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        !load_codes |=> $stable(digit_codes_reg))
        else $error("digit codes changed without a matched frame");

endmodule

// ===== src/fdss_scan.sv =====
`timescale 1ns / 1ps

module fdss_scan
    import fdss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tick_en,
    input  code_arr_t  digit_codes,
    input  logic       out_stall,
    output logic       out_free,
    output logic       out_valid,
    output logic [1:0] digit_index,
    output logic [7:0] segments
);

    logic [1:0] scan_pos_reg;
    logic       out_valid_reg;
    logic [1:0] digit_index_reg;
    logic [7:0] segments_reg;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_pos_reg    <= 2'd0;
            out_valid_reg   <= 1'b0;
            digit_index_reg <= 2'd0;
            segments_reg    <= 8'd0;
        end
        else
        begin
            if (tick_en)
            begin
                scan_pos_reg    <= scan_pos_reg + 2'd1;
                out_valid_reg   <= 1'b1;
                digit_index_reg <= scan_pos_reg;
                segments_reg    <= segments_for(digit_codes[scan_pos_reg]);
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign digit_index = digit_index_reg;
    assign segments    = segments_reg;

    a_tick_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        tick_en |-> out_free)
        else $error("tick loaded over an unread result");

    a_scan_steps: assert property (@(posedge clk) disable iff (!rst_n)
        tick_en |=> scan_pos_reg == 2'($past(scan_pos_reg) + 2'd1))
        else $error("scan position did not advance");

endmodule

// ===== src/framed_four_digit_seven_segment_scanner.sv =====
// Four-digit seven-segment scanner with a framed serial loader. Each request is a
// received byte (req_type 0) or a scan tick (req_type 1). Bytes build frames of
// 'X', six payload bytes, 'Y'; a good frame loads the four digit codes from the
// first four payload bytes, a bad end byte drops it. Each tick returns the next
// digit index and its segment pattern (a..g in bits 0..6, point in bit 7); bytes
// return nothing. One request is taken every cycle while the input is not stalled: an
// input register feeds the frame hunter and the segment decode, and a result register
// drives the output, so a tick's result is loaded into the result register at the
// same edge at which the tick leaves the input register.
// Only a tick waiting behind a stalled result holds up the input.
`timescale 1ns / 1ps

module framed_four_digit_seven_segment_scanner
    import fdss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       req_type,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] digit_index,
    output logic [7:0] segments
);

    logic       s1_valid_reg;
    logic       s1_type_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_adv;
    logic       out_free;
    logic       tick_en;
    byte_req_t  byte_req;
    code_arr_t  digit_codes;

    assign s1_adv   = s1_valid_reg && ((s1_type_reg == REQ_BYTE) || out_free);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign tick_en  = s1_adv && (s1_type_reg == REQ_TICK);

    assign byte_req.en   = s1_adv && (s1_type_reg == REQ_BYTE);
    assign byte_req.data = s1_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_type_reg  <= REQ_BYTE;
            s1_byte_reg  <= 8'd0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                s1_valid_reg <= 1'b1;
                s1_type_reg  <= req_type;
                s1_byte_reg  <= rx_byte;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    fdss_framer u_framer (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_req    (byte_req),
        .digit_codes (digit_codes)
    );

    fdss_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_en     (tick_en),
        .digit_codes (digit_codes),
        .out_stall   (out_stall),
        .out_free    (out_free),
        .out_valid   (out_valid),
        .digit_index (digit_index),
        .segments    (segments)
    );

    // only a tick can be held back, and only by a stalled result
    a_stall_is_tick: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_type_reg == REQ_TICK) && out_valid && out_stall)
        else $error("input stalled without a blocked tick");

    a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(tick_en))
        else $error("result appeared without a tick");

endmodule

// ===== tb/framed_four_digit_seven_segment_scanner_tb.sv =====
`timescale 1ns / 1ps

module framed_four_digit_seven_segment_scanner_tb;
    import fdss_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       req_type;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] digit_index;
    logic [7:0] segments;

    typedef struct packed {
        logic [1:0] idx;
        logic [7:0] seg;
    } scan_result_t;

    typedef struct {
        logic       kind;
        logic [7:0] b;
        bit         typed;
        logic [1:0] idx;
        logic [7:0] seg;
    } script_row_t;

    localparam int ScriptLen = 27;

    // rows with typed results: reset digits, wrap, extreme codes, dropped frame
    script_row_t script [ScriptLen] = '{
        '{REQ_TICK, 8'h00, 1'b1, 2'd0, 8'h06},
        '{REQ_TICK, 8'hFF, 1'b1, 2'd1, 8'h5B},
        '{REQ_TICK, 8'h55, 1'b1, 2'd2, 8'h4F},
        '{REQ_TICK, 8'hAA, 1'b1, 2'd3, 8'h66},
        '{REQ_TICK, 8'h00, 1'b1, 2'd0, 8'h06},
        '{REQ_BYTE, START_BYTE, 1'b0, 2'd0, 8'h00},
        '{REQ_BYTE, 8'h00, 1'b0, 2'd0, 8'h00},
        '{REQ_BYTE, 8'hFF, 1'b0, 2'd0, 8'h00},
        '{REQ_BYTE, 8'h49, 1'b0, 2'd0, 8'h00},
        '{REQ_BYTE, 8'h46, 1'b0, 2'd0, 8'h00},
        '{REQ_BYTE, START_BYTE, 1'b0, 2'd0, 8'h00},
        '{REQ_BYTE, END_BYTE, 1'b0, 2'd0, 8'h00},
        '{REQ_BYTE, END_BYTE, 1'b0, 2'd0, 8'h00},
        '{REQ_TICK, 8'h00, 1'b1, 2'd1, 8'h00},
        '{REQ_TICK, 8'h00, 1'b1, 2'd2, 8'hE7},
        '{REQ_TICK, 8'h00, 1'b1, 2'd3, 8'hFD},
        '{REQ_TICK, 8'h00, 1'b1, 2'd0, 8'h3F},
        '{REQ_BYTE, START_BYTE, 1'b0, 2'd0, 8'h00},
        '{REQ_BYTE, 8'h0A, 1'b0, 2'd0, 8'h00},
        '{REQ_BYTE, 8'h1B, 1'b0, 2'd0, 8'h00},
        '{REQ_BYTE, 8'h77, 1'b0, 2'd0, 8'h00},
        '{REQ_BYTE, 8'h35, 1'b0, 2'd0, 8'h00},
        '{REQ_BYTE, 8'hAA, 1'b0, 2'd0, 8'h00},
        '{REQ_BYTE, 8'h55, 1'b0, 2'd0, 8'h00},
        '{REQ_BYTE, START_BYTE, 1'b0, 2'd0, 8'h00},
        '{REQ_TICK, 8'h00, 1'b1, 2'd1, 8'h00},
        '{REQ_TICK, 8'h00, 1'b0, 2'd0, 8'h00}
    };

    // predictor state
    logic [2:0]   hunt_phase;
    code_t        frame_codes [NumDigits];
    code_t        shown_codes [NumDigits];
    logic [1:0]   scan_pos;

    scan_result_t due_scans [$];
    int           err_count;
    int           sent_count;
    int           ignored_count;
    int           scans_checked;
    int           frames_loaded;
    int           frames_dropped;
    int           idle_pct;
    int           stall_pct;

    framed_four_digit_seven_segment_scanner uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digit_index (digit_index),
        .segments    (segments)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        #400000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [7:0] glyph_for(input code_t code);
        logic [6:0] bars;
        case (code[3:0])
            4'd0:    bars = 7'h3F;
            4'd1:    bars = 7'h06;
            4'd2:    bars = 7'h5B;
            4'd3:    bars = 7'h4F;
            4'd4:    bars = 7'h66;
            4'd5:    bars = 7'h6D;
            4'd6:    bars = 7'h7D;
            4'd7:    bars = 7'h07;
            4'd8:    bars = 7'h7F;
            4'd9:    bars = 7'h67;
            default: return 8'h00;
        endcase
        return {code[4], bars};
    endfunction

    task automatic advance_scanner(input logic kind, input logic [7:0] b,
                                   output bit lit, output scan_result_t res);
        lit = 1'b0;
        res = '0;
        if (kind == REQ_TICK)
        begin
            lit = 1'b1;
            res.idx = scan_pos;
            res.seg = glyph_for(shown_codes[scan_pos]);
            scan_pos = scan_pos + 2'd1;
        end
        else if (hunt_phase == PH_HUNT)
        begin
            if (b == START_BYTE)
                hunt_phase = 3'd1;
        end
        else if (hunt_phase != PH_END)
        begin
            // payload bytes five and six are swallowed
            if (hunt_phase <= PH_LAST_KEEP)
                frame_codes[hunt_phase[1:0] - 2'd1] = {b[6], b[3:0]};
            hunt_phase = hunt_phase + 3'd1;
        end
        else
        begin
            if (b == END_BYTE)
            begin
                shown_codes = frame_codes;
                frames_loaded++;
            end
            else
            begin
                frames_dropped++;
            end
            hunt_phase = PH_HUNT;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        err_count++;
    endtask

    // called at a rising edge; returns at the edge that accepted the request
    task automatic send_item(input logic kind, input logic [7:0] b, input bit typed,
                             input logic [1:0] t_idx, input logic [7:0] t_seg);
        bit           lit;
        scan_result_t res;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_scanner(kind, b, lit, res);
        if (lit)
        begin
            if (typed)
            begin
                res.idx = t_idx;
                res.seg = t_seg;
            end
            due_scans.push_back(res);
        end
        sent_count++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(REQ_BYTE, b, 1'b0, 2'd0, 8'h00);
    endtask

    task automatic send_tick();
        send_item(REQ_TICK, 8'($urandom_range(0, 255)), 1'b0, 2'd0, 8'h00);
    endtask

    task automatic maybe_tick();
        if ($urandom_range(0, 99) < 30)
            send_tick();
    endtask

    task automatic send_frame(input bit good, input int keep);
        logic [7:0] b;
        maybe_tick();
        send_byte(START_BYTE);
        for (int i = 0; i < keep; i++)
        begin
            b = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 1)
                b[3:0] = 4'($urandom_range(0, 9));
            maybe_tick();
            send_byte(b);
        end
        if (keep == 6)
        begin
            if (good)
            begin
                b = END_BYTE;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                b = START_BYTE;
            end
            else
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == END_BYTE);
            end
            maybe_tick();
            send_byte(b);
        end
        // up to five ticks so fresh digits get shown
        repeat ($urandom_range(0, 5))
            send_tick();
    endtask

    task automatic run_phase(input int budget, input int idle, input int stall);
        int first;
        int pick;
        idle_pct  = idle;
        stall_pct = stall;
        first     = sent_count - ignored_count;
        while (sent_count - ignored_count - first < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                send_frame(1'b1, 6);
            end
            else if (pick < 75)
            begin
                send_frame(1'b0, 6);
            end
            else if (pick < 85)
            begin
                // truncated frame: the next start byte lands in its payload
                send_frame(1'b1, $urandom_range(0, 5));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(0, 1) == 1)
                    begin
                        send_tick();
                    end
                    else
                    begin
                        send_byte(8'($urandom_range(0, 255)));
                        if (hunt_phase == PH_HUNT)
                            ignored_count++;
                    end
                end
            end
        end
    endtask

    task automatic drain_scans();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (due_scans.size() != 0);
    endtask

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin : scan_check
        scan_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_scans.size() == 0)
            begin
                report_mismatch($sformatf("unexpected scan idx %0d seg %02h",
                                          digit_index, segments));
            end
            else
            begin
                want = due_scans.pop_front();
                scans_checked++;
                if (digit_index !== want.idx)
                    report_mismatch($sformatf("digit_index %0d, want %0d",
                                              digit_index, want.idx));
                if (segments !== want.seg)
                    report_mismatch($sformatf("segments %02h, want %02h (digit %0d)",
                                              segments, want.seg, want.idx));
            end
        end
    end

    initial
    begin
        err_count      = 0;
        sent_count     = 0;
        ignored_count  = 0;
        scans_checked  = 0;
        frames_loaded  = 0;
        frames_dropped = 0;
        idle_pct       = 0;
        stall_pct      = 0;
        hunt_phase     = PH_HUNT;
        scan_pos       = 2'd0;
        for (int i = 0; i < NumDigits; i++)
        begin
            frame_codes[i] = '0;
            shown_codes[i] = code_t'(i + 1);
        end
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        req_type  <= REQ_BYTE;
        rx_byte   <= 8'h00;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            send_item(script[i].kind, script[i].b, script[i].typed,
                      script[i].idx, script[i].seg);

        run_phase(180, 0, 0);
        run_phase(170, 87, 0);
        // hold off until the display has caught up
        drain_scans();
        run_phase(170, 0, 87);
        run_phase(180, 9, 9);

        drain_scans();
        stall_pct = 0;
        repeat (10)
            @(posedge clk);

        $display("Sent %0d requests (tick and byte, all idle and stall mixes), %0d scans checked",
                 sent_count, scans_checked);
        $display("Frames loaded: %0d, frames dropped on a bad end byte: %0d",
                 frames_loaded, frames_dropped);
        if (err_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
